/* rtl/core/prf_pkg.sv */
// Package for the packet ring FIFO.
// Field widths, result codes and fill status codes; no dependencies.
package prf_pkg;

    localparam int BYTE_W = 8;
    localparam int CHAN_W = 7;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;
    localparam int FILL_W = 2;
    localparam int OCC_W  = 4;

    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
    localparam logic [FILL_W-1:0] FILL_INUSE = 2'd1;
    localparam logic [FILL_W-1:0] FILL_FULL  = 2'd2;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic [CHAN_W-1:0] out_channel;
        logic [LEN_W-1:0]  out_length;
        logic              end_of_packet;
        logic [FILL_W-1:0] fill_status;
        logic [OCC_W-1:0]  occupancy;
        logic              dropped;
        logic              truncated;
    } result_t;

endpackage

/* rtl/core/prf_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the payload store and the slot descriptor store; no dependencies.
module prf_ram #(
    parameter int WIDTH  = 8,
    parameter int WORDS  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/packet_ring_fifo.sv */
// Top level of the packet ring FIFO: slot pointers, assembly counter,
// read sequencer and result register. Uses prf_pkg and prf_ram.
//
// Usage:
//   Input channel item_valid/item_stall carries action, data_byte, last and
//   channel. A write item stores one byte of the packet under assembly; the
//   item marked last commits it and gives one status result. A read item
//   gives one result per stored byte of the oldest packet, or one empty
//   result when the ring holds nothing.
//   Output channel result_valid/result_stall carries the results; a write
//   item not marked last gives none. A commit or empty result is registered
//   and shown the cycle after its item. A read passes the descriptor RAM, the
//   payload RAM output stage and the result register, then gives one byte per
//   cycle while the receiver does not stall; the input stalls through a read
//   until the last byte has left the RAM output stage. Write items are taken
//   one per cycle. Reset empties the ring and clears the assembly state; the
//   stores need no clearing, since no slot is read before it is committed.
//   While the receiver stalls, the result register and the RAM output stage
//   hold; the input stalls until the result register can take a result.
module packet_ring_fifo #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         action,
    input  logic [prf_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last,
    input  logic [prf_pkg::CHAN_W-1:0]   channel,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [prf_pkg::KIND_W-1:0]   kind,
    output logic [prf_pkg::BYTE_W-1:0]   out_byte,
    output logic [prf_pkg::CHAN_W-1:0]   out_channel,
    output logic [prf_pkg::LEN_W-1:0]    out_length,
    output logic                         end_of_packet,
    output logic [prf_pkg::FILL_W-1:0]   fill_status,
    output logic [prf_pkg::OCC_W-1:0]    occupancy,
    output logic                         dropped,
    output logic                         truncated
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int HELD_W  = SLOT_W + 1;
    localparam int CNT_W   = $clog2(PAYLOAD_BYTES + 1);
    localparam int WORDS   = DEPTH * PAYLOAD_BYTES;
    localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DESC_W  = CNT_W + prf_pkg::CHAN_W;
    localparam int OCCX_W  = (HELD_W > prf_pkg::OCC_W) ? HELD_W : prf_pkg::OCC_W;
    localparam int LENX_W  = (CNT_W > prf_pkg::LEN_W) ? CNT_W : prf_pkg::LEN_W;

    localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(DEPTH - 1);
    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(DEPTH - 1);
    localparam logic [HELD_W-1:0] HELD_WRAP = HELD_W'(DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]      byte_cnt_reg, byte_cnt_next;
    logic                  overflow_reg, overflow_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic [CNT_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_last_reg, rd_last_next;
    logic [prf_pkg::FILL_W-1:0] st_fill_reg, st_fill_next;
    logic [prf_pkg::OCC_W-1:0]  st_occ_reg, st_occ_next;
    logic                  out_valid_reg, out_valid_next;
    prf_pkg::result_t      out_reg, out_next;

    logic                  accept;
    logic                  out_load;
    logic                  rd_take;
    logic                  issue;
    logic [HELD_W-1:0]     held;
    logic [HELD_W-1:0]     held_inc;
    logic [HELD_W-1:0]     held_dec;
    logic                  ring_full;
    logic                  has_room;
    logic [CNT_W-1:0]      commit_len;
    logic [SLOT_W-1:0]     wr_slot_inc;
    logic [SLOT_W-1:0]     rd_slot_inc;
    logic [OCCX_W-1:0]     occ_inc_x;
    logic [OCCX_W-1:0]     occ_dec_x;
    logic [OCCX_W-1:0]     occ_cur_x;
    logic [LENX_W-1:0]     commit_len_x;
    logic [LENX_W-1:0]     desc_len_x;

    logic                  pay_we;
    logic [ADDR_W-1:0]     pay_waddr;
    logic [ADDR_W-1:0]     pay_raddr;
    logic [prf_pkg::BYTE_W-1:0] pay_rdata;
    logic                  desc_we;
    logic                  desc_re;
    logic [DESC_W-1:0]     desc_rdata;
    logic [CNT_W-1:0]      desc_len;
    logic [prf_pkg::CHAN_W-1:0] desc_chan;

    function automatic logic [prf_pkg::FILL_W-1:0] fill_of(
        input logic [HELD_W-1:0] n,
        input logic [HELD_W-1:0] full_at
    );
        if (n == '0)
        begin
            return prf_pkg::FILL_EMPTY;
        end
        else if (n >= full_at)
        begin
            return prf_pkg::FILL_FULL;
        end
        return prf_pkg::FILL_INUSE;
    endfunction

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE) || (out_valid_reg && result_stall);
    assign out_load   = !out_valid_reg || !result_stall;
    assign rd_take    = rd_valid_reg && out_load;
    assign issue      = (state_reg == S_STREAM) && (issue_cnt_reg != desc_len)
                        && (!rd_valid_reg || rd_take);

    assign held = ({1'b0, wr_slot_reg} + ((wr_slot_reg < rd_slot_reg) ? HELD_WRAP : '0))
                  - {1'b0, rd_slot_reg};
    assign held_inc  = held + HELD_W'(1);
    assign held_dec  = held - HELD_W'(1);
    assign ring_full = (held >= HELD_FULL);
    assign has_room  = (byte_cnt_reg < CNT_MAX);
    assign commit_len = has_room ? byte_cnt_reg + CNT_W'(1) : byte_cnt_reg;

    assign wr_slot_inc = (wr_slot_reg == SLOT_MAX) ? '0 : wr_slot_reg + SLOT_W'(1);
    assign rd_slot_inc = (rd_slot_reg == SLOT_MAX) ? '0 : rd_slot_reg + SLOT_W'(1);

    assign occ_inc_x    = OCCX_W'(held_inc);
    assign occ_dec_x    = OCCX_W'(held_dec);
    assign occ_cur_x    = OCCX_W'(held);
    assign commit_len_x = LENX_W'(commit_len);
    assign desc_len_x   = LENX_W'(desc_len);

    assign desc_len  = desc_rdata[DESC_W-1 -: CNT_W];
    assign desc_chan = desc_rdata[prf_pkg::CHAN_W-1:0];

    assign pay_we    = accept && (action == prf_pkg::ACTION_WRITE) && has_room;
    assign pay_waddr = ADDR_W'(wr_slot_reg) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(byte_cnt_reg);
    assign pay_raddr = ADDR_W'(cur_slot_reg) * ADDR_W'(PAYLOAD_BYTES)
                       + ADDR_W'(issue_cnt_reg);
    assign desc_we   = accept && (action == prf_pkg::ACTION_WRITE) && last && !ring_full;
    assign desc_re   = accept && (action == prf_pkg::ACTION_READ) && (held != '0);

    prf_ram #(
        .WIDTH  (prf_pkg::BYTE_W),
        .WORDS  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (data_byte),
        .re    (issue),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    prf_ram #(
        .WIDTH  (DESC_W),
        .WORDS  (DEPTH),
        .ADDR_W (SLOT_W)
    ) u_desc (
        .clk   (clk),
        .we    (desc_we),
        .waddr (wr_slot_reg),
        .wdata ({commit_len, channel}),
        .re    (desc_re),
        .raddr (rd_slot_reg),
        .rdata (desc_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_slot_next   = rd_slot_reg;
        wr_slot_next   = wr_slot_reg;
        byte_cnt_next  = byte_cnt_reg;
        overflow_next  = overflow_reg;
        cur_slot_next  = cur_slot_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_valid_next  = rd_valid_reg;
        rd_last_next   = rd_last_reg;
        st_fill_next   = st_fill_reg;
        st_occ_next    = st_occ_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_load)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == prf_pkg::ACTION_WRITE))
                begin
                    if (has_room)
                    begin
                        byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last)
                    begin
                        byte_cnt_next          = '0;
                        overflow_next          = 1'b0;
                        out_valid_next         = 1'b1;
                        out_next.kind          = prf_pkg::KIND_COMMIT;
                        out_next.out_byte      = '0;
                        out_next.out_channel   = channel;
                        out_next.out_length    = commit_len_x[prf_pkg::LEN_W-1:0];
                        out_next.end_of_packet = 1'b1;
                        out_next.dropped       = ring_full;
                        out_next.truncated     = overflow_reg || !has_room;
                        if (ring_full)
                        begin
                            out_next.fill_status = fill_of(held, HELD_FULL);
                            out_next.occupancy   = occ_cur_x[prf_pkg::OCC_W-1:0];
                        end
                        else
                        begin
                            wr_slot_next         = wr_slot_inc;
                            out_next.fill_status = fill_of(held_inc, HELD_FULL);
                            out_next.occupancy   = occ_inc_x[prf_pkg::OCC_W-1:0];
                        end
                    end
                end
                else if (accept)
                begin
                    if (held == '0)
                    begin
                        out_valid_next         = 1'b1;
                        out_next.kind          = prf_pkg::KIND_EMPTY;
                        out_next.out_byte      = '0;
                        out_next.out_channel   = '0;
                        out_next.out_length    = '0;
                        out_next.end_of_packet = 1'b1;
                        out_next.fill_status   = prf_pkg::FILL_EMPTY;
                        out_next.occupancy     = '0;
                        out_next.dropped       = 1'b0;
                        out_next.truncated     = 1'b0;
                    end
                    else
                    begin
                        state_next     = S_STREAM;
                        cur_slot_next  = rd_slot_reg;
                        rd_slot_next   = rd_slot_inc;
                        issue_cnt_next = '0;
                        st_fill_next   = fill_of(held_dec, HELD_FULL);
                        st_occ_next    = occ_dec_x[prf_pkg::OCC_W-1:0];
                    end
                end
            end
            S_STREAM:
            begin
                if (rd_take)
                begin
                    rd_valid_next          = 1'b0;
                    out_valid_next         = 1'b1;
                    out_next.kind          = prf_pkg::KIND_DATA;
                    out_next.out_byte      = pay_rdata;
                    out_next.out_channel   = desc_chan;
                    out_next.out_length    = desc_len_x[prf_pkg::LEN_W-1:0];
                    out_next.end_of_packet = rd_last_reg;
                    out_next.fill_status   = st_fill_reg;
                    out_next.occupancy     = st_occ_reg;
                    out_next.dropped       = 1'b0;
                    out_next.truncated     = 1'b0;
                end
                if (issue)
                begin
                    rd_valid_next  = 1'b1;
                    rd_last_next   = (issue_cnt_reg + CNT_W'(1) == desc_len);
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if ((issue_cnt_next == desc_len) && !rd_valid_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_slot_reg   <= '0;
            wr_slot_reg   <= '0;
            byte_cnt_reg  <= '0;
            overflow_reg  <= 1'b0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_slot_reg   <= rd_slot_next;
            wr_slot_reg   <= wr_slot_next;
            byte_cnt_reg  <= byte_cnt_next;
            overflow_reg  <= overflow_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        rd_last_reg  <= rd_last_next;
        st_fill_reg  <= st_fill_next;
        st_occ_reg   <= st_occ_next;
        out_reg      <= out_next;
    end

    assign result_valid  = out_valid_reg;
    assign kind          = out_reg.kind;
    assign out_byte      = out_reg.out_byte;
    assign out_channel   = out_reg.out_channel;
    assign out_length    = out_reg.out_length;
    assign end_of_packet = out_reg.end_of_packet;
    assign fill_status   = out_reg.fill_status;
    assign occupancy     = out_reg.occupancy;
    assign dropped       = out_reg.dropped;
    assign truncated     = out_reg.truncated;

`ifndef NO_ASSERTIONS
    a_rd_stage_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_STREAM))
        else $error("RAM output stage holds a byte outside a read");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> (issue_cnt_reg <= desc_len))
        else $error("read sequencer issued past the packet length");

    a_commit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        desc_we |=> (wr_slot_reg != $past(wr_slot_reg)))
        else $error("committed packet did not advance the write slot");

    a_no_pointer_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == prf_pkg::ACTION_WRITE) && last && ring_full)
        |=> (wr_slot_reg == $past(wr_slot_reg)))
        else $error("write slot moved on a dropped packet");
`endif

endmodule
